### hdl/mer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and constants of the midpoint ellipse rasterizer: datapath
// micro-operations, the command and status bundles and sequence lengths.
// ----------------------------------------------------------------------------
package mer_pkg;

   // datapath micro-operations, one per cycle
   typedef enum logic [4:0] {
      OP_NONE,
      OP_START,       // load center, radii, axis swap
      OP_SQ_MAJ,      // major squared
      OP_SQ_MIN,      // minor squared
      OP_INIT_YG,     // major^2 * minor
      OP_INIT_DEC,    // initial region-1 decision
      OP_SW_TX,       // (2x+1)^2
      OP_SW_TY,       // (y-1)^2
      OP_SW_MI,       // minor^2 * (2x+1)^2
      OP_SW_MA,       // major^2 * (y-1)^2
      OP_SW_MM,       // major^2 * minor^2
      OP_SW_END,      // enter region 2
      OP_STEP,        // move x / y, latch points to plot
      OP_MUL_FIRST,
      OP_WB_FIRST,
      OP_MUL_SECOND,
      OP_WB_SECOND
   } mer_op_type;

   typedef struct packed {
      mer_op_type op;
      logic [1:0] idx;      // which of the four symmetric points is shown
   } mer_cmd_type;

   typedef struct packed {
      logic active;         // an ellipse is being drawn
      logic region2;
      logic grad_lt;        // x gradient below y gradient
      logic two;            // current iteration updates both axes
   } mer_status_type;

   localparam logic       KIND_START  = 1'b0;
   localparam logic [2:0] INIT_LAST   = 3'd3;
   localparam logic [2:0] SWITCH_LAST = 3'd5;
   localparam logic [1:0] EMIT_LAST   = 2'd3;

endpackage
`default_nettype wire

### hdl/midpoint_ellipse_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse rasterizer stepped one iteration per item, with the
// decision variable held scaled by four in exact integer arithmetic.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                          | tuser         | tlast
//  req_    | in  | first_x, first_y, second_x, second_y        | kind          | -
//  rsp_    | out | point_x, point_y                            | ellipse_done  | last_of_step
//
//  Sequence: a start item runs the start operation, then the setup steps (major squared,
//  minor squared, major^2 * minor, initial decision). A step item runs the step operation
//  and a multiply and write-back per moved axis, then shows the four points; the step
//  that enters region 2 first runs the region switch. A step with no ellipse active is
//  accepted and ignored. The sequence is set by the single shared multiplier, one product
//  a cycle. Reset is synchronous; no clearing pass. rsp_tready low holds the current
//  point and stretches the item by the stalled cycles.
//
module midpoint_ellipse_rasterizer
   import mer_pkg::*;
#(
   parameter int COORD_BITS = 11
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // first_x, first_y, second_x, second_y, zero pad
   input  wire logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // kind
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // point_x, point_y, zero pad
   output logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0]      rsp_tdata,
   // ellipse_done
   output logic                        rsp_tuser,
   // last_of_step
   output logic                        rsp_tlast
);

   localparam int CB         = COORD_BITS;
   localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

   mer_cmd_type    cmd;
   mer_status_type status;
   logic [CB-1:0]  point_x, point_y;

   // sequencer: one micro-operation to the datapath per cycle
   mer_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_last  (rsp_tlast),
      .status    (status),
      .cmd       (cmd)
   );

   // corner fields are only sampled on the start operation, which the
   // controller issues in the accept cycle
   mer_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .first_x      (req_tdata[CB-1:0]),
      .first_y      (req_tdata[2*CB-1:CB]),
      .second_x     (req_tdata[3*CB-1:2*CB]),
      .second_y     (req_tdata[4*CB-1:3*CB]),
      .status       (status),
      .point_x      (point_x),
      .point_y      (point_y),
      .ellipse_done (rsp_tuser)
   );

   assign rsp_tdata = OUT_DATA_W'({point_y, point_x});

endmodule
`default_nettype wire

### hdl/mer_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_datapath
// Ellipse state, one shared signed multiplier with a product register, and
// the point generator for the four symmetric points.
// ----------------------------------------------------------------------------
module mer_datapath
   import mer_pkg::*;
#(
   parameter int COORD_BITS = 11
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mer_cmd_type           cmd,
   input  wire logic [COORD_BITS-1:0] first_x,
   input  wire logic [COORD_BITS-1:0] first_y,
   input  wire logic [COORD_BITS-1:0] second_x,
   input  wire logic [COORD_BITS-1:0] second_y,
   output mer_status_type             status,
   output logic [COORD_BITS-1:0]      point_x,
   output logic [COORD_BITS-1:0]      point_y,
   output logic                       ellipse_done
);

   localparam int CB     = COORD_BITS;
   localparam int RAD_W  = CB - 1;
   localparam int SQ_W   = 2 * CB - 2;
   localparam int T_W    = 2 * CB;
   localparam int MUL_W  = 2 * CB + 1;
   localparam int DEC_W  = 4 * CB - 4;
   localparam int GRAD_W = 3 * CB - 1;

   logic [CB-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic [RAD_W-1:0]  major_ff, major_in, minor_ff, minor_in;
   logic              swapped_ff, swapped_in;
   logic [CB-1:0]     x_ff, x_in, y_ff, y_in;       // two's complement
   logic [SQ_W-1:0]   ma2_ff, ma2_in, mi2_ff, mi2_in;
   logic [DEC_W-1:0]  dec_ff, dec_in;               // decision times four
   logic [GRAD_W-1:0] xg_ff, xg_in, yg_ff, yg_in;
   logic              region2_ff, region2_in, active_ff, active_in;
   logic              two_ff, two_in, done_ff, done_in;
   logic [DEC_W-1:0]  prod_ff, prod_in;
   logic [T_W-1:0]    tsq_ff, tsq_in;
   logic [CB-1:0]     a_ff, a_in, b_ff, b_in;

   // start geometry
   logic [CB-1:0] diff_x, diff_y;
   logic [CB:0]   sum_x, sum_y;
   logic [RAD_W-1:0] rad_x, rad_y;

   assign diff_x = (first_x > second_x) ? first_x - second_x : second_x - first_x;
   assign diff_y = (first_y > second_y) ? first_y - second_y : second_y - first_y;
   assign sum_x  = {1'b0, first_x} + {1'b0, second_x};
   assign sum_y  = {1'b0, first_y} + {1'b0, second_y};
   assign rad_x  = diff_x[CB-1:1];
   assign rad_y  = diff_y[CB-1:1];

   // multiplier operands, extended to MUL_W: magnitudes with zeros, coordinates with their sign
   logic signed [MUL_W-1:0] major_ext, minor_ext, ma2_ext, mi2_ext, tsq_ext;
   logic signed [MUL_W-1:0] x_ext, y_ext, tx_ext, ty_ext;
   logic        [CB:0]      ty;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_full;

   assign ty        = {y_ff[CB-1], y_ff} - (CB + 1)'(1);
   assign major_ext = {{(MUL_W - RAD_W){1'b0}}, major_ff};
   assign minor_ext = {{(MUL_W - RAD_W){1'b0}}, minor_ff};
   assign ma2_ext   = {{(MUL_W - SQ_W){1'b0}}, ma2_ff};
   assign mi2_ext   = {{(MUL_W - SQ_W){1'b0}}, mi2_ff};
   assign tsq_ext   = {{(MUL_W - T_W){1'b0}}, tsq_ff};
   assign x_ext     = {{(MUL_W - CB){x_ff[CB-1]}}, x_ff};
   assign y_ext     = {{(MUL_W - CB){y_ff[CB-1]}}, y_ff};
   assign tx_ext    = {{(MUL_W - CB - 1){x_ff[CB-1]}}, x_ff, 1'b1};
   assign ty_ext    = {{(MUL_W - CB - 1){ty[CB]}}, ty};
   assign mul_full  = mul_a * mul_b;

   // scaled terms
   logic [DEC_W-1:0]  mi2_x4, ma2_x4, ma2_x1, prod_x4, prod_x8;
   logic [GRAD_W-1:0] prod_x2;
   logic              dec_neg, dec_pos;

   assign mi2_x4  = {{(DEC_W - SQ_W - 2){1'b0}}, mi2_ff, 2'b00};
   assign ma2_x4  = {{(DEC_W - SQ_W - 2){1'b0}}, ma2_ff, 2'b00};
   assign ma2_x1  = {{(DEC_W - SQ_W){1'b0}}, ma2_ff};
   assign prod_x4 = {prod_ff[DEC_W-3:0], 2'b00};
   assign prod_x8 = {prod_ff[DEC_W-4:0], 3'b000};
   assign prod_x2 = {prod_ff[GRAD_W-2:0], 1'b0};
   assign dec_neg = dec_ff[DEC_W-1];
   assign dec_pos = !dec_neg && (dec_ff != '0);

   always_comb begin
      cx_in = cx_ff;   cy_in = cy_ff;
      major_in = major_ff;   minor_in = minor_ff;   swapped_in = swapped_ff;
      x_in = x_ff;   y_in = y_ff;
      ma2_in = ma2_ff;   mi2_in = mi2_ff;
      dec_in = dec_ff;   xg_in = xg_ff;   yg_in = yg_ff;
      region2_in = region2_ff;   active_in = active_ff;
      two_in = two_ff;   done_in = done_ff;
      prod_in = prod_ff;   tsq_in = tsq_ff;
      a_in = a_ff;   b_in = b_ff;
      mul_a = major_ext;
      mul_b = major_ext;

      unique case (cmd.op) inside
         OP_NONE: begin
         end
         OP_START: begin
            cx_in      = sum_x[CB:1];
            cy_in      = sum_y[CB:1];
            swapped_in = rad_y > rad_x;
            major_in   = (rad_y > rad_x) ? rad_y : rad_x;
            minor_in   = (rad_y > rad_x) ? rad_x : rad_y;
            x_in       = '0;
            y_in       = {1'b0, ((rad_y > rad_x) ? rad_x : rad_y)};
            xg_in      = '0;
            region2_in = 1'b0;
            active_in  = 1'b1;
         end
         OP_SQ_MAJ: begin
            prod_in = mul_full[DEC_W-1:0];
         end
         OP_SQ_MIN: begin
            ma2_in  = prod_ff[SQ_W-1:0];
            mul_a   = minor_ext;
            mul_b   = minor_ext;
            prod_in = mul_full[DEC_W-1:0];
         end
         OP_INIT_YG: begin
            mi2_in  = prod_ff[SQ_W-1:0];
            mul_a   = ma2_ext;
            mul_b   = minor_ext;
            prod_in = mul_full[DEC_W-1:0];
         end
         OP_INIT_DEC: begin
            yg_in  = prod_x2;
            dec_in = mi2_x4 + ma2_x1 - prod_x4;
         end
         OP_SW_TX: begin
            mul_a   = tx_ext;
            mul_b   = tx_ext;
            prod_in = mul_full[DEC_W-1:0];
         end
         OP_SW_TY: begin
            tsq_in  = prod_ff[T_W-1:0];
            mul_a   = ty_ext;
            mul_b   = ty_ext;
            prod_in = mul_full[DEC_W-1:0];
         end
         OP_SW_MI: begin
            tsq_in  = prod_ff[T_W-1:0];
            mul_a   = mi2_ext;
            mul_b   = tsq_ext;
            prod_in = mul_full[DEC_W-1:0];
         end
         OP_SW_MA: begin
            dec_in  = prod_ff;
            mul_a   = ma2_ext;
            mul_b   = tsq_ext;
            prod_in = mul_full[DEC_W-1:0];
         end
         OP_SW_MM: begin
            dec_in  = dec_ff + prod_x4;
            mul_a   = ma2_ext;
            mul_b   = mi2_ext;
            prod_in = mul_full[DEC_W-1:0];
         end
         OP_SW_END: begin
            dec_in     = dec_ff - prod_x4;
            region2_in = 1'b1;
         end
         OP_STEP: begin
            a_in = swapped_ff ? y_ff : x_ff;
            b_in = swapped_ff ? x_ff : y_ff;
            if (!region2_ff) begin
               x_in    = x_ff + CB'(1);
               two_in  = !dec_neg;
               if (!dec_neg) y_in = y_ff - CB'(1);
               dec_in  = dec_ff + mi2_x4;
               done_in = 1'b0;
            end else begin
               y_in    = y_ff - CB'(1);
               two_in  = !dec_pos;
               if (!dec_pos) x_in = x_ff + CB'(1);
               dec_in  = dec_ff + ma2_x4;
               done_in = (y_ff == '0);
               if (y_ff == '0) active_in = 1'b0;
            end
         end
         OP_MUL_FIRST, OP_MUL_SECOND: begin
            // region 1 moves x first, region 2 moves y first
            if (region2_ff == (cmd.op == OP_MUL_FIRST)) begin
               mul_a = ma2_ext;
               mul_b = y_ext;
            end else begin
               mul_a = mi2_ext;
               mul_b = x_ext;
            end
            prod_in = mul_full[DEC_W-1:0];
         end
         OP_WB_FIRST, OP_WB_SECOND: begin
            if (region2_ff == (cmd.op == OP_WB_FIRST)) begin
               yg_in  = prod_x2;
               dec_in = dec_ff - prod_x8;
            end else begin
               xg_in  = prod_x2;
               dec_in = dec_ff + prod_x8;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         region2_ff <= 1'b0;
      end else begin
         active_ff  <= active_in;
         region2_ff <= region2_in;
      end
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      major_ff   <= major_in;
      minor_ff   <= minor_in;
      swapped_ff <= swapped_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      ma2_ff     <= ma2_in;
      mi2_ff     <= mi2_in;
      dec_ff     <= dec_in;
      xg_ff      <= xg_in;
      yg_ff      <= yg_in;
      two_ff     <= two_in;
      done_ff    <= done_in;
      prod_ff    <= prod_in;
      tsq_ff     <= tsq_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
   end

   assign status.active  = active_ff;
   assign status.region2 = region2_ff;
   assign status.grad_lt = $signed(xg_ff) < $signed(yg_ff);
   assign status.two     = two_ff;

   // idx bit 1 negates a, bit 0 negates b
   assign point_x      = cmd.idx[1] ? cx_ff - a_ff : cx_ff + a_ff;
   assign point_y      = cmd.idx[0] ? cy_ff - b_ff : cy_ff + b_ff;
   assign ellipse_done = done_ff && (cmd.idx == EMIT_LAST);

endmodule
`default_nettype wire

### hdl/mer_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mer_controller
// Sequencer: accepts items, walks the datapath through setup, region switch
// and one iteration, then presents the four points.
// ----------------------------------------------------------------------------
module mer_controller
   import mer_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_kind,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic                rsp_last,
   input  wire mer_status_type status,
   output mer_cmd_type         cmd
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_INIT   = 9'b000000010,
      ST_SWITCH = 9'b000000100,
      ST_STEP   = 9'b000001000,
      ST_MUL1   = 9'b000010000,
      ST_WB1    = 9'b000100000,
      ST_MUL2   = 9'b001000000,
      ST_WB2    = 9'b010000000,
      ST_EMIT   = 9'b100000000
   } mer_state_type;

   mer_state_type state_ff, state_in;
   logic [2:0]    cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_NONE;
      cmd.idx  = cnt_ff[1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_START) begin
                  cmd.op   = OP_START;
                  state_in = ST_INIT;
                  cnt_in   = '0;
               end else if (status.active) begin
                  if (!status.region2 && !status.grad_lt) begin
                     state_in = ST_SWITCH;
                     cnt_in   = '0;
                  end else begin
                     state_in = ST_STEP;
                  end
               end
            end
         end
         ST_INIT: begin
            case (cnt_ff)
               3'd0:    cmd.op = OP_SQ_MAJ;
               3'd1:    cmd.op = OP_SQ_MIN;
               3'd2:    cmd.op = OP_INIT_YG;
               default: cmd.op = OP_INIT_DEC;
            endcase
            if (cnt_ff == INIT_LAST) state_in = ST_IDLE;
            else cnt_in = cnt_ff + 3'd1;
         end
         ST_SWITCH: begin
            case (cnt_ff)
               3'd0:    cmd.op = OP_SW_TX;
               3'd1:    cmd.op = OP_SW_TY;
               3'd2:    cmd.op = OP_SW_MI;
               3'd3:    cmd.op = OP_SW_MA;
               3'd4:    cmd.op = OP_SW_MM;
               default: cmd.op = OP_SW_END;
            endcase
            if (cnt_ff == SWITCH_LAST) state_in = ST_STEP;
            else cnt_in = cnt_ff + 3'd1;
         end
         ST_STEP: begin
            cmd.op   = OP_STEP;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.op   = OP_MUL_FIRST;
            state_in = ST_WB1;
         end
         ST_WB1: begin
            cmd.op   = OP_WB_FIRST;
            cnt_in   = '0;
            state_in = status.two ? ST_MUL2 : ST_EMIT;
         end
         ST_MUL2: begin
            cmd.op   = OP_MUL_SECOND;
            state_in = ST_WB2;
         end
         ST_WB2: begin
            cmd.op   = OP_WB_SECOND;
            cnt_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (cnt_ff[1:0] == EMIT_LAST) state_in = ST_IDLE;
               else cnt_in = cnt_ff + 3'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_last  = (state_ff == ST_EMIT) && (cnt_ff[1:0] == EMIT_LAST);

   // input and output sides never open together
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while points are pending");

   // no item shows a point in the cycle right after it is accepted
   a_no_early_point: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("point shown too early");

   // last point of an iteration hands back to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("not idle after last point");

   a_init_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> (cnt_ff <= INIT_LAST))
      else $error("setup count out of range");

endmodule
`default_nettype wire

### tb/tb_midpoint_ellipse_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midpoint_ellipse_rasterizer
// Self-checking bench for the midpoint ellipse rasterizer. Start and step
// items go in on the req_ stream, and every plotted point on the rsp_ stream
// is compared with a point predicted in the bench from its own copy of the
// ellipse state. Directed cases come first, then random ellipses under
// changing backpressure.
// ----------------------------------------------------------------------------
module tb_midpoint_ellipse_rasterizer;
   import mer_pkg::*;

   localparam int   COORD_BITS = 11;
   localparam int   REQ_W      = 48;     // 4 x 11 bits, padded to bytes
   localparam int   RSP_W      = 24;     // 2 x 11 bits, padded to bytes
   localparam logic KIND_STEP  = 1'b1;   // KIND_START comes from the package
   localparam int   COORD_MAX  = (1 << COORD_BITS) - 1;

   typedef bit [COORD_BITS-1:0] coord_type;

   // one plotted point as it should leave the block
   typedef struct {
      coord_type px;
      coord_type py;
      bit        last;
      bit        done;
   } point_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;   // first_x, first_y, second_x, second_y, pad
   logic               req_tuser = 1'b0; // kind
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;        // point_x, point_y, pad
   logic               rsp_tuser;        // ellipse_done
   logic               rsp_tlast;        // last_of_step

   // points still owed by the block, oldest first
   point_type pending_points[$];
   int     mismatches = 0;
   int     items_counted = 0;   // items that did something (not ignored steps)
   int     req_idle_pct = 0;
   int     rsp_idle_pct = 0;

   // ellipse state as the bench sees it
   bit [63:0] ctr_x, ctr_y, rad_major, rad_minor;
   bit        swapped;
   longint    cur_x, cur_y;
   bit [63:0] dec4;             // decision value times four, wraps at 64 bits
   longint    grad_x, grad_y;
   bit        region2;
   bit        drawing;

   midpoint_ellipse_rasterizer #(.COORD_BITS(COORD_BITS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // ---------------------------------------------------------------------
   // Ellipse predictor
   // ---------------------------------------------------------------------
   task automatic reset_ellipse();
      ctr_x = 0; ctr_y = 0; rad_major = 0; rad_minor = 0;
      swapped = 0; cur_x = 0; cur_y = 0; dec4 = 0;
      grad_x = 0; grad_y = 0; region2 = 0; drawing = 0;
   endtask

   task automatic push_point(input bit [63:0] px, input bit [63:0] py,
                             input bit last, input bit done);
      point_type p;
      p.px = px[COORD_BITS-1:0];
      p.py = py[COORD_BITS-1:0];
      p.last = last;
      p.done = done;
      pending_points.push_back(p);
   endtask

   // apply one accepted item, queue the points it plots
   task automatic plot_item(input logic kind, input coord_type fx, input coord_type fy,
                            input coord_type sx, input coord_type sy);
      bit [63:0] ma2, mi2, rx, ry, tx, ty, a, b;
      bit        dec_neg, dec_pos, done;
      ma2 = rad_major * rad_major;
      mi2 = rad_minor * rad_minor;
      if (kind == KIND_START) begin
         rx = ((fx > sx) ? 64'(fx - sx) : 64'(sx - fx)) >> 1;
         ry = ((fy > sy) ? 64'(fy - sy) : 64'(sy - fy)) >> 1;
         ctr_x = (64'(fx) + 64'(sx)) >> 1;
         ctr_y = (64'(fy) + 64'(sy)) >> 1;
         swapped = ry > rx;
         rad_major = swapped ? ry : rx;
         rad_minor = swapped ? rx : ry;
         ma2 = rad_major * rad_major;
         mi2 = rad_minor * rad_minor;
         cur_x = 0;
         cur_y = $signed(rad_minor);
         grad_x = 0;
         grad_y = $signed(64'd2 * ma2 * rad_minor);
         dec4 = 64'd4 * mi2 + ma2 - 64'd4 * ma2 * rad_minor;
         region2 = 0;
         drawing = 1;
         return;
      end
      if (!drawing) return;

      // region switch: set up the region-2 decision, then iterate there
      if (!region2 && !(grad_x < grad_y)) begin
         tx = 64'd2 * 64'(cur_x) + 64'd1;
         ty = 64'(cur_y - 1);
         region2 = 1;
         dec4 = mi2 * tx * tx + 64'd4 * ma2 * ty * ty - 64'd4 * ma2 * mi2;
         grad_x = $signed(64'd2 * mi2 * 64'(cur_x));
         grad_y = $signed(64'd2 * ma2 * 64'(cur_y));
      end
      if (region2 && cur_y < 0) begin
         drawing = 0;
         return;
      end

      a = swapped ? 64'(cur_y) : 64'(cur_x);
      b = swapped ? 64'(cur_x) : 64'(cur_y);

      if (!region2) begin
         dec_neg = dec4[63];
         cur_x += 1;
         grad_x = $signed(64'd2 * mi2 * 64'(cur_x));
         if (dec_neg) begin
            dec4 += 64'd4 * 64'(grad_x) + 64'd4 * mi2;
         end else begin
            cur_y -= 1;
            grad_y = $signed(64'd2 * ma2 * 64'(cur_y));
            dec4 += 64'd4 * 64'(grad_x) - 64'd4 * 64'(grad_y) + 64'd4 * mi2;
         end
         done = 0;
      end else begin
         dec_pos = !dec4[63] && dec4 != 0;
         cur_y -= 1;
         grad_y = $signed(64'd2 * ma2 * 64'(cur_y));
         if (dec_pos) begin
            dec4 += 64'd4 * ma2 - 64'd4 * 64'(grad_y);
         end else begin
            cur_x += 1;
            grad_x = $signed(64'd2 * mi2 * 64'(cur_x));
            dec4 += 64'd4 * 64'(grad_x) - 64'd4 * 64'(grad_y) + 64'd4 * ma2;
         end
         done = cur_y < 0;
         if (done) drawing = 0;
      end

      // quadrant order: (+a,+b) (+a,-b) (-a,+b) (-a,-b)
      push_point(ctr_x + a, ctr_y + b, 0, 0);
      push_point(ctr_x + a, ctr_y - b, 0, 0);
      push_point(ctr_x - a, ctr_y + b, 0, 0);
      push_point(ctr_x - a, ctr_y - b, 1, done);
   endtask

   // ---------------------------------------------------------------------
   // Sender: drive at the falling edge, hold until accepted
   // ---------------------------------------------------------------------
   task automatic send_item(input logic kind, input coord_type fx, input coord_type fy,
                            input coord_type sx, input coord_type sy);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {4'b0, sy, sx, fy, fx};
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_START || drawing) items_counted++;
      plot_item(kind, fx, fy, sx, sy);
   endtask

   task automatic start_ellipse(input coord_type fx, input coord_type fy,
                                input coord_type sx, input coord_type sy);
      send_item(KIND_START, fx, fy, sx, sy);
   endtask

   // step fields are don't-care, keep them moving anyway
   task automatic step_ellipse();
      send_item(KIND_STEP, coord_type'($urandom), coord_type'($urandom),
                coord_type'($urandom), coord_type'($urandom));
   endtask

   task automatic walk_to_end();
      while (drawing) step_ellipse();
   endtask

   // sender holds off until the block has delivered everything owed
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
   endtask

   // two corner coordinates at most span apart, either order
   task automatic pick_span(output coord_type p, output coord_type q, input int span);
      int d;
      int base;
      base = $urandom_range(COORD_MAX);
      d = $urandom_range(span);
      p = coord_type'(base);
      q = (base + d <= COORD_MAX) ? coord_type'(base + d) : coord_type'(base - d);
      if ($urandom_range(1)) {p, q} = {q, p};
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stall, check every accepted point
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : point_check
      point_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_points.size() == 0) begin
            report_mismatch("point with none owed", rsp_tdata[COORD_BITS-1:0], -1);
         end else begin
            want = pending_points.pop_front();
            if (rsp_tdata[COORD_BITS-1:0] !== want.px)
               report_mismatch("point_x", rsp_tdata[COORD_BITS-1:0], want.px);
            if (rsp_tdata[2*COORD_BITS-1:COORD_BITS] !== want.py)
               report_mismatch("point_y", rsp_tdata[2*COORD_BITS-1:COORD_BITS], want.py);
            if (rsp_tlast !== want.last)
               report_mismatch("last_of_step", rsp_tlast, want.last);
            if (rsp_tuser !== want.done)
               report_mismatch("ellipse_done", rsp_tuser, want.done);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------
   task automatic test_step_when_idle();
      step_ellipse();                      // nothing drawn yet: no points
   endtask

   task automatic test_zero_radius();
      start_ellipse(11'd2047, 11'd2047, 11'd2047, 11'd2047);
      step_ellipse();                      // four copies of the center, done
      step_ellipse();                      // finished: ignored
      start_ellipse(11'd0, 11'd0, 11'd1, 11'd1);
      step_ellipse();
   endtask

   task automatic test_extreme_corners();
      start_ellipse(11'd0, 11'd0, 11'd2047, 11'd2047);
      repeat (3) step_ellipse();
      start_ellipse(11'd2047, 11'd0, 11'd0, 11'd2047);  // replaces the big one
      repeat (2) step_ellipse();
   endtask

   // vertical radius larger: axes swap, points transpose
   task automatic test_swapped_axes();
      start_ellipse(11'd20, 11'd10, 11'd22, 11'd16);
      walk_to_end();
   endtask

   // new start mid-ellipse, corners given high-to-low, then run past the end
   task automatic test_restart_and_switch();
      start_ellipse(11'd100, 11'd200, 11'd108, 11'd210);
      repeat (2) step_ellipse();
      start_ellipse(11'd309, 11'd44, 11'd300, 11'd40);
      walk_to_end();
      step_ellipse();
   endtask

   // ---------------------------------------------------------------------
   // Random phase: mostly whole small ellipses, some big partial ones,
   // abandoned ellipses and loose items
   // ---------------------------------------------------------------------
   task automatic test_random_phase(input int req_pct, input int rsp_pct,
                                    input int quota);
      int        stop_at;
      int        pick;
      coord_type fx, fy, sx, sy;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      stop_at = items_counted + quota;
      wait_drained();
      while (items_counted < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            pick_span(fx, sx, 12);
            pick_span(fy, sy, 12);
            start_ellipse(fx, fy, sx, sy);
            if ($urandom_range(9) == 0) begin
               repeat ($urandom_range(1, 4)) step_ellipse();
            end else begin
               walk_to_end();
               if ($urandom_range(2) == 0) step_ellipse();
            end
         end else if (pick < 80) begin
            start_ellipse(coord_type'($urandom), coord_type'($urandom),
                          coord_type'($urandom), coord_type'($urandom));
            repeat ($urandom_range(1, 6)) step_ellipse();
         end else if (pick < 92) begin
            send_item(logic'($urandom_range(1)), coord_type'($urandom),
                      coord_type'($urandom), coord_type'($urandom),
                      coord_type'($urandom));
         end else begin
            wait_drained();
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset_ellipse();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_step_when_idle();
      test_zero_radius();
      test_extreme_corners();
      test_swapped_axes();
      test_restart_and_switch();

      test_random_phase(25, 45, 40);
      test_random_phase(45, 25, 40);
      test_random_phase(0, 0, 30);

      wait_drained();
      repeat (40) @(posedge clock);
      if (pending_points.size() != 0)
         report_mismatch("points never delivered", 0, pending_points.size());
      if (mismatches == 0) begin
         $display("tb_midpoint_ellipse_rasterizer OK");
      end else begin
         $display("tb_midpoint_ellipse_rasterizer NOT OK");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #4_000_000;
      $display("tb_midpoint_ellipse_rasterizer NOT OK");
      $finish;
   end

endmodule
